FILE: hw/rtl/pnrf_pkg.sv
// ---------------------------------------------------------------------------
// Polynomial Newton root finder package
// Shared constants, status codes, request types and saturation helpers.
// ---------------------------------------------------------------------------
package pnrf_pkg;

  // Number of coefficients that take part in the evaluation (2 .. 8).
  localparam int NUM_COEFFS = 8;

  localparam int NREGS      = 8;
  localparam int REG_IDX_W  = 3;
  localparam int ADDR_W     = 5;
  localparam int Q_W        = 32;
  localparam int FRAC_W     = 16;
  localparam int TOL_W      = 31;
  localparam int ITER_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int DIVIDEND_W = Q_W + FRAC_W;
  localparam int DIV_CNT_W  = 6;

  typedef logic signed [Q_W-1:0] q_t;

  localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FLAT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic                  start;
    logic                  neg;
    logic [DIVIDEND_W-1:0] dividend;
    logic [Q_W-1:0]        divisor;
  } div_req_t;

  // Response from the divider: quotient valid while done is high.
  typedef struct packed {
    logic done;
    q_t   quot;
  } div_rsp_t;

  // Saturate a 33-bit signed value to the Q16.16 range.
  function automatic q_t sat33(input logic signed [Q_W:0] v);
    q_t r;
    if (v[Q_W] != v[Q_W-1]) begin
      r = v[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // Saturate a 48-bit signed value to the Q16.16 range.
  function automatic q_t sat48(input logic signed [DIVIDEND_W-1:0] v);
    q_t r;
    if ((&v[DIVIDEND_W-1:Q_W-1]) || !(|v[DIVIDEND_W-1:Q_W-1])) begin
      r = v[Q_W-1:0];
    end else begin
      r = v[DIVIDEND_W-1] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/pnrf_mul.sv
// ---------------------------------------------------------------------------
// Shared fixed-point multiplier
// Q16.16 product, floored to 16 fraction bits and saturated, registered.
// ---------------------------------------------------------------------------
module pnrf_mul
  import pnrf_pkg::*;
(
  input  logic clk,
  input  q_t   a,
  input  q_t   b,
  output q_t   q
);

  logic signed [2*Q_W-1:0] prod;
  q_t                      q_r;

  // An arithmetic shift right of the full product is the floor.
  assign prod = a * b;

  always_ff @(posedge clk) begin
    q_r <= sat48(prod[2*Q_W-1:FRAC_W]);
  end

  assign q = q_r;

endmodule

FILE: hw/rtl/pnrf_div.sv
// ---------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle, sign applied and saturated.
// ---------------------------------------------------------------------------
module pnrf_div
  import pnrf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [DIVIDEND_W-1:0] MAG_LIM_NEG = DIVIDEND_W'(64'h0000_0000_8000_0000);
  localparam logic [DIVIDEND_W-1:0] MAG_LIM_POS = DIVIDEND_W'(64'h0000_0000_7FFF_FFFF);

  logic                  run_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [Q_W-1:0]        rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [Q_W-1:0]        dvs_r;
  logic                  neg_r;

  logic [Q_W:0]          shifted;
  logic [Q_W+1:0]        diff;
  logic                  qbit;
  q_t                    quot;

  assign shifted = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign qbit    = !diff[Q_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
      neg_r <= req.neg;
    end else if (run_r) begin
      rem_r <= qbit ? diff[Q_W-1:0] : shifted[Q_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], qbit};
    end
  end

  always_comb begin
    if (neg_r) begin
      quot = (quo_r > MAG_LIM_NEG) ? Q_MIN : q_t'(-quo_r[Q_W-1:0]);
    end else begin
      quot = (quo_r > MAG_LIM_POS) ? Q_MAX : q_t'(quo_r[Q_W-1:0]);
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot;

endmodule

FILE: hw/rtl/polynomial_newton_root_finder.sv
// ---------------------------------------------------------------------------
// Polynomial Newton root finder
// Finds one root of a polynomial of degree up to seven by Newton's method,
// in signed Q16.16 fixed point, with one shared multiplier and one divider.
// ---------------------------------------------------------------------------
// Each Newton step passes through an iteration state, then a multiply state and
// an add state per Horner step of p(x) and p'(x) through the shared multiplier,
// then a check state and the bit-serial divider. Busy stays high until the run
// ends and a new request is taken only while idle, so one request is in flight
// at a time; the receiver cannot stall the strobe.
// Reset (rst_n low, synchronous) clears the sequencer, strobe and coefficients.
// ---------------------------------------------------------------------------
module polynomial_newton_root_finder
  import pnrf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel
  input  logic                  start,
  output logic                  busy,
  input  logic signed [Q_W-1:0] in_start_guess,
  input  logic [TOL_W-1:0]      in_tolerance,
  input  logic [ITER_W-1:0]     in_iteration_limit,
  // Result channel
  output logic                  out_valid,
  output logic signed [Q_W-1:0] out_root,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ITER_W-1:0]     out_iterations_used,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [Q_W-1:0]        pwdata,
  output logic [Q_W-1:0]        prdata,
  output logic                  pready
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ITER  = 3'd1;
  localparam logic [2:0] S_PMUL  = 3'd2;
  localparam logic [2:0] S_PADD  = 3'd3;
  localparam logic [2:0] S_DMUL  = 3'd4;
  localparam logic [2:0] S_DADD  = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;
  localparam logic [2:0] S_DIV   = 3'd7;

  localparam logic [REG_IDX_W-1:0] IDX_TOP = REG_IDX_W'(NUM_COEFFS - 1);

  // -------------------------------------------------------------------------
  // Coefficient store. Eight words held in a small memory with one write
  // port and two registered read ports: one for the bus, one for the
  // sequencer. A valid bit per entry makes an unwritten entry read as zero,
  // which is the reset value of every coefficient.
  // -------------------------------------------------------------------------
  q_t                  coef_mem [NREGS];
  logic [NREGS-1:0]    cval_r;
  q_t                  coef_rd_r;
  logic [Q_W-1:0]      prdata_r;
  logic                cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      coef_mem[cfg_idx] <= q_t'(pwdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cval_r <= '0;
    end else if (cfg_wr) begin
      cval_r[cfg_idx] <= 1'b1;
    end
  end

  // Bus read port: the address is stable from the setup cycle on, so the
  // registered word is ready in the access cycle.
  always_ff @(posedge clk) begin
    prdata_r <= cval_r[cfg_idx] ? coef_mem[cfg_idx] : '0;
  end

  assign prdata = prdata_r;
  assign pready = 1'b1;

  // -------------------------------------------------------------------------
  // Sequencer registers.
  // -------------------------------------------------------------------------
  logic [2:0]           state_r, state_nxt;
  q_t                   x_r, x_nxt;
  logic [TOL_W-1:0]     tol_r, tol_nxt;
  logic [ITER_W-1:0]    limit_r, limit_nxt;
  logic [ITER_W-1:0]    k_r, k_nxt;
  q_t                   acc_r, acc_nxt;
  logic [REG_IDX_W-1:0] idx_r, idx_nxt;
  q_t                   p_r, p_nxt;
  q_t                   d_r, d_nxt;
  logic                 out_valid_r, out_valid_nxt;
  q_t                   out_root_r, out_root_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [ITER_W-1:0]    out_used_r, out_used_nxt;

  // Sequencer read port: the index in place during a multiply cycle delivers
  // its coefficient in the following add cycle.
  always_ff @(posedge clk) begin
    coef_rd_r <= cval_r[idx_r] ? coef_mem[idx_r] : '0;
  end

  // Shared units.
  q_t       mul_q;
  div_req_t div_req;
  div_rsp_t div_rsp;

  pnrf_mul u_mul (
    .clk (clk),
    .a   (acc_r),
    .b   (x_r),
    .q   (mul_q)
  );

  pnrf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // -------------------------------------------------------------------------
  // Datapath around the shared units.
  // -------------------------------------------------------------------------
  logic signed [Q_W+REG_IDX_W:0] dprod;
  q_t                            dcoef;
  q_t                            addend;
  q_t                            horner_sum;
  logic [Q_W-1:0]                p_mag;
  logic [Q_W-1:0]                d_mag;
  logic                          p_small;
  logic                          d_small;
  q_t                            x_upd;

  // Derivative coefficient i*c_i is a small product by the 3-bit index.
  assign dprod  = $signed({1'b0, idx_r}) * coef_rd_r;
  assign dcoef  = sat48(DIVIDEND_W'(dprod));
  assign addend = (state_r == S_DADD) ? dcoef : coef_rd_r;

  // One Horner step: the floored product from the multiplier plus the
  // coefficient, or i*c_i in the derivative pass, saturated.
  assign horner_sum = sat33({mul_q[Q_W-1], mul_q} + {addend[Q_W-1], addend});

  // Exact magnitudes; the most negative value maps to 2^31 as unsigned.
  assign p_mag = p_r[Q_W-1] ? (~p_r + 1'b1) : p_r;
  assign d_mag = d_r[Q_W-1] ? (~d_r + 1'b1) : d_r;

  assign p_small = p_mag < {1'b0, tol_r};
  assign d_small = (d_mag < {1'b0, tol_r}) || (d_r == '0);

  // The quotient p/p' is taken as (|p| << 16) / |p'| with the sign applied
  // by the divider afterward.
  assign div_req.start    = (state_r == S_CHECK) && !p_small && !d_small;
  assign div_req.neg      = p_r[Q_W-1] ^ d_r[Q_W-1];
  assign div_req.dividend = {p_mag, {FRAC_W{1'b0}}};
  assign div_req.divisor  = d_mag;

  assign x_upd = sat33({x_r[Q_W-1], x_r} - {div_rsp.quot[Q_W-1], div_rsp.quot});

  // -------------------------------------------------------------------------
  // Sequencer. Each Newton step evaluates p(x) from the top coefficient down,
  // then p'(x) from the top derivative coefficient down to index one, checks
  // both magnitudes against the tolerance and either reports or divides and
  // moves x.
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    tol_nxt        = tol_r;
    limit_nxt      = limit_r;
    k_nxt          = k_r;
    acc_nxt        = acc_r;
    idx_nxt        = idx_r;
    p_nxt          = p_r;
    d_nxt          = d_r;
    out_valid_nxt  = 1'b0;
    out_root_nxt   = out_root_r;
    out_status_nxt = out_status_r;
    out_used_nxt   = out_used_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          x_nxt     = in_start_guess;
          tol_nxt   = in_tolerance;
          limit_nxt = in_iteration_limit;
          k_nxt     = '0;
          state_nxt = S_ITER;
        end
      end
      S_ITER: begin
        if (k_r == limit_r) begin
          // Limit reached without a decision.
          out_valid_nxt  = 1'b1;
          out_root_nxt   = '0;
          out_status_nxt = ST_LIMIT;
          out_used_nxt   = limit_r;
          state_nxt      = S_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          acc_nxt   = '0;
          idx_nxt   = IDX_TOP;
          state_nxt = S_PMUL;
        end
      end
      S_PMUL: begin
        state_nxt = S_PADD;
      end
      S_PADD: begin
        if (idx_r == '0) begin
          p_nxt     = horner_sum;
          acc_nxt   = '0;
          idx_nxt   = IDX_TOP;
          state_nxt = S_DMUL;
        end else begin
          acc_nxt   = horner_sum;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_PMUL;
        end
      end
      S_DMUL: begin
        state_nxt = S_DADD;
      end
      S_DADD: begin
        if (idx_r == REG_IDX_W'(1)) begin
          d_nxt     = horner_sum;
          state_nxt = S_CHECK;
        end else begin
          acc_nxt   = horner_sum;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_DMUL;
        end
      end
      S_CHECK: begin
        if (p_small) begin
          out_valid_nxt  = 1'b1;
          out_root_nxt   = x_r;
          out_status_nxt = ST_FOUND;
          out_used_nxt   = k_r;
          state_nxt      = S_IDLE;
        end else if (d_small) begin
          // A flat or exactly zero derivative ends the run.
          out_valid_nxt  = 1'b1;
          out_root_nxt   = '0;
          out_status_nxt = ST_FLAT;
          out_used_nxt   = k_r;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          x_nxt     = x_upd;
          state_nxt = S_ITER;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    tol_r        <= tol_nxt;
    limit_r      <= limit_nxt;
    k_r          <= k_nxt;
    acc_r        <= acc_nxt;
    idx_r        <= idx_nxt;
    p_r          <= p_nxt;
    d_r          <= d_nxt;
    out_root_r   <= out_root_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_root            = out_root_r;
  assign out_status          = out_status_r;
  assign out_iterations_used = out_used_r;

endmodule

FILE: hw/rtl/pnrf_checker.sv
// ---------------------------------------------------------------------------
// Polynomial Newton root finder checker
// Port-level assertions on request and result behavior over time.
// ---------------------------------------------------------------------------
module pnrf_checker
  import pnrf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic signed [Q_W-1:0] out_root,
  input logic [STATUS_W-1:0]   out_status,
  input logic [ITER_W-1:0]     out_iterations_used
);

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // The block goes idle exactly when it delivers the result.
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result strobe");

  // Each result strobe lasts one cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A result without a root reports zero in the root field.
  a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_FOUND) |-> (out_root == '0))
    else $error("root field not zero for a failed run");

  // A decision inside a step counts at least that step.
  a_used_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_LIMIT) |-> (out_iterations_used != '0))
    else $error("decided run reports zero iterations");

endmodule

bind polynomial_newton_root_finder pnrf_checker u_pnrf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_root            (out_root),
  .out_status          (out_status),
  .out_iterations_used (out_iterations_used)
);
